FILE: hw/rtl/epipolar_inlier_scorer_macros.svh
// assertion helpers used by eis_back
`ifndef EPIPOLAR_INLIER_SCORER_MACROS_SVH
`define EPIPOLAR_INLIER_SCORER_MACROS_SVH

// same-cycle implication, disabled in reset
`define EIS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define EIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/eis_pkg.sv
package eis_pkg;

    localparam int unsigned MAX_POINTS = 4096;
    localparam int unsigned CNT_W      = 13;
    localparam int unsigned CNT_LIMIT  = 8191;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned ROW_W      = 48;
    localparam int unsigned THR_W      = 32;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 48;
    localparam int unsigned IN_DATA_W  = 96;
    localparam int unsigned OUT_DATA_W = 16;

    localparam int unsigned MUL_W   = 35;
    localparam int unsigned PROD_W  = 2 * MUL_W;
    localparam int unsigned F_W     = 34;
    localparam int unsigned R_W     = 52;
    localparam int unsigned RMAG_W  = R_W - 1;
    localparam int unsigned R_SPLIT = 26;
    localparam int unsigned D_W     = 67;
    localparam int unsigned D_SPLIT = 34;
    localparam int unsigned LHS_W   = 2 * RMAG_W;
    localparam int unsigned RHS_W   = D_W + THR_W + 1;
    localparam int unsigned N_STEPS = 27;
    localparam int unsigned STEP_W  = 5;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_E_ROW0   = 3'd0,
        CFG_E_ROW1   = 3'd1,
        CFG_E_ROW2   = 3'd2,
        CFG_THRESH   = 3'd3,
        CFG_SAMPSON  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [ROW_W-1:0] e_row0;
        logic [ROW_W-1:0] e_row1;
        logic [ROW_W-1:0] e_row2;
        logic [THR_W-1:0] thresh;
        logic             use_sampson;
    } t_cfg;

    typedef struct packed {
        logic signed [WORD_W-1:0] p1_x;
        logic signed [WORD_W-1:0] p1_y;
        logic signed [WORD_W-1:0] p1_z;
        logic signed [WORD_W-1:0] p2_x;
        logic signed [WORD_W-1:0] p2_y;
        logic signed [WORD_W-1:0] p2_z;
        logic                     last;
    } t_item;

    typedef enum logic [4:0] {
        S_E00, S_E01, S_E02, S_E10, S_E11, S_E12, S_E20, S_E21, S_E22,
        S_P1X, S_P1Y, S_P1Z, S_P2X, S_P2Y, S_P2Z,
        S_F10, S_F11, S_F12, S_F20, S_F21,
        S_RH, S_RL, S_DL, S_DH, S_T
    } t_src;

    typedef enum logic [3:0] {
        D_F10, D_F11, D_F12, D_F20, D_F21, D_R, D_D,
        D_LHS_HI, D_LHS_MID, D_LHS_LO, D_RHS_LO, D_RHS_HI
    } t_dst;

    typedef struct packed {
        t_src a;
        t_src b;
        t_dst dst;
    } t_step;

    // microcode of the multiply-accumulate sequence
    function automatic t_step step_op(input logic [STEP_W-1:0] s);
        t_step op;
        op = '{a: S_T, b: S_DH, dst: D_RHS_HI};
        case (s)
            5'd0:  op = '{a: S_E00, b: S_P1X, dst: D_F10};
            5'd1:  op = '{a: S_E01, b: S_P1Y, dst: D_F10};
            5'd2:  op = '{a: S_E02, b: S_P1Z, dst: D_F10};
            5'd3:  op = '{a: S_E10, b: S_P1X, dst: D_F11};
            5'd4:  op = '{a: S_E11, b: S_P1Y, dst: D_F11};
            5'd5:  op = '{a: S_E12, b: S_P1Z, dst: D_F11};
            5'd6:  op = '{a: S_E20, b: S_P1X, dst: D_F12};
            5'd7:  op = '{a: S_E21, b: S_P1Y, dst: D_F12};
            5'd8:  op = '{a: S_E22, b: S_P1Z, dst: D_F12};
            5'd9:  op = '{a: S_E00, b: S_P2X, dst: D_F20};
            5'd10: op = '{a: S_E10, b: S_P2Y, dst: D_F20};
            5'd11: op = '{a: S_E20, b: S_P2Z, dst: D_F20};
            5'd12: op = '{a: S_E01, b: S_P2X, dst: D_F21};
            5'd13: op = '{a: S_E11, b: S_P2Y, dst: D_F21};
            5'd14: op = '{a: S_E21, b: S_P2Z, dst: D_F21};
            5'd15: op = '{a: S_P2X, b: S_F10, dst: D_R};
            5'd16: op = '{a: S_P2Y, b: S_F11, dst: D_R};
            5'd17: op = '{a: S_P2Z, b: S_F12, dst: D_R};
            5'd18: op = '{a: S_F10, b: S_F10, dst: D_D};
            5'd19: op = '{a: S_F11, b: S_F11, dst: D_D};
            5'd20: op = '{a: S_F20, b: S_F20, dst: D_D};
            5'd21: op = '{a: S_F21, b: S_F21, dst: D_D};
            5'd22: op = '{a: S_RH, b: S_RH, dst: D_LHS_HI};
            5'd23: op = '{a: S_RH, b: S_RL, dst: D_LHS_MID};
            5'd24: op = '{a: S_RL, b: S_RL, dst: D_LHS_LO};
            5'd25: op = '{a: S_T, b: S_DL, dst: D_RHS_LO};
            default: op = '{a: S_T, b: S_DH, dst: D_RHS_HI};
        endcase
        return op;
    endfunction

endpackage

FILE: hw/rtl/epipolar_inlier_scorer.sv
// Scores point correspondences against an essential-matrix hypothesis held in
// configuration registers, giving an inlier flag and a running inlier count per
// word (the count clears after a word marked last). One shared 35x35 multiplier
// runs 27 multiply-accumulate steps per correspondence, each a multiply state
// then an accumulate state, after an idle state and before a done state. A
// two-word input queue lets the upstream side run ahead by two words, and the
// result register lets the next word start while a result waits downstream.
// Write configuration only while no word is in flight.
module epipolar_inlier_scorer #(
    parameter int unsigned MAX_POINTS = eis_pkg::MAX_POINTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z
    input  logic [eis_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    input  logic                            i_s_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // is_inlier, inlier_total, zero pad
    output logic [eis_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    output logic                            o_m_axis_tlast,
    input  logic                            i_cfg_we,
    input  logic [eis_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [eis_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    eis_pkg::t_cfg  r_cfg;
    eis_pkg::t_item w_item;
    logic           w_item_valid, w_item_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.e_row0      <= '0;
            r_cfg.e_row1      <= '0;
            r_cfg.e_row2      <= '0;
            r_cfg.thresh      <= '0;
            r_cfg.use_sampson <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (eis_pkg::t_cfg_idx'(i_cfg_addr))
                eis_pkg::CFG_E_ROW0:  r_cfg.e_row0      <= i_cfg_data;
                eis_pkg::CFG_E_ROW1:  r_cfg.e_row1      <= i_cfg_data;
                eis_pkg::CFG_E_ROW2:  r_cfg.e_row2      <= i_cfg_data;
                eis_pkg::CFG_THRESH:  r_cfg.thresh      <= i_cfg_data[eis_pkg::THR_W-1:0];
                eis_pkg::CFG_SAMPSON: r_cfg.use_sampson <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    eis_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_item_valid    (w_item_valid),
        .i_item_ready    (w_item_ready),
        .o_item          (w_item)
    );

    eis_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_item_valid    (w_item_valid),
        .o_item_ready    (w_item_ready),
        .i_item          (w_item),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

FILE: hw/rtl/eis_front.sv
module eis_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z
    input  logic [eis_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    input  logic                               i_s_axis_tlast,
    output logic                               o_item_valid,
    input  logic                               i_item_ready,
    output eis_pkg::t_item                     o_item
);

    eis_pkg::t_item r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           w_push, w_pop;
    eis_pkg::t_item w_in;

    assign o_s_axis_tready = (r_cnt != 2'd2);
    assign o_item_valid    = (r_cnt != 2'd0);
    assign o_item          = r_mem[r_rp];
    assign w_push          = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pop           = o_item_valid && i_item_ready;

    always_comb begin
        w_in.p1_x = i_s_axis_tdata[15:0];
        w_in.p1_y = i_s_axis_tdata[31:16];
        w_in.p1_z = i_s_axis_tdata[47:32];
        w_in.p2_x = i_s_axis_tdata[63:48];
        w_in.p2_y = i_s_axis_tdata[79:64];
        w_in.p2_z = i_s_axis_tdata[95:80];
        w_in.last = i_s_axis_tlast;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

FILE: hw/rtl/eis_back.sv
`include "epipolar_inlier_scorer_macros.svh"

module eis_back #(
    parameter int unsigned MAX_POINTS = eis_pkg::MAX_POINTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  eis_pkg::t_cfg                 i_cfg,
    input  logic                          i_item_valid,
    output logic                          o_item_ready,
    input  eis_pkg::t_item                i_item,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // is_inlier, inlier_total, zero pad
    output logic [eis_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                          o_m_axis_tlast
);

    localparam int unsigned CAP_INT = (MAX_POINTS < eis_pkg::CNT_LIMIT) ?
                                      MAX_POINTS : eis_pkg::CNT_LIMIT;
    localparam logic [eis_pkg::CNT_W-1:0] COUNT_CAP = eis_pkg::CNT_W'(CAP_INT);
    localparam logic [eis_pkg::STEP_W-1:0] LAST_STEP =
        eis_pkg::STEP_W'(eis_pkg::N_STEPS - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ACC, ST_DONE} t_state;

    t_state                              r_state;
    logic [eis_pkg::STEP_W-1:0]          r_step;
    eis_pkg::t_item                      r_item;
    logic signed [eis_pkg::PROD_W-1:0]   r_prod;
    logic signed [eis_pkg::F_W-1:0]      r_f10, r_f11, r_f12, r_f20, r_f21;
    logic signed [eis_pkg::R_W-1:0]      r_r;
    logic [eis_pkg::D_W-1:0]             r_d;
    logic [eis_pkg::LHS_W-1:0]           r_lhs;
    logic [eis_pkg::RHS_W-1:0]           r_rhs;
    logic [eis_pkg::CNT_W-1:0]           r_count;
    logic                                r_out_valid;
    logic                                r_out_inlier;
    logic [eis_pkg::CNT_W-1:0]           r_out_total;
    logic                                r_out_last;

    eis_pkg::t_step                      w_op;
    logic [eis_pkg::R_W-1:0]             w_rabs;
    logic [eis_pkg::RMAG_W-1:0]          w_rmag;
    logic signed [eis_pkg::MUL_W-1:0]    w_va, w_vb;
    logic                                w_inl;
    logic                                w_load;
    logic [eis_pkg::CNT_W-1:0]           w_total;

    function automatic logic signed [eis_pkg::MUL_W-1:0] ent(
        input logic [eis_pkg::ROW_W-1:0] row, input int unsigned k);
        logic signed [eis_pkg::WORD_W-1:0] v;
        v = row[eis_pkg::WORD_W*k +: eis_pkg::WORD_W];
        return eis_pkg::MUL_W'(v);
    endfunction

    function automatic logic signed [eis_pkg::MUL_W-1:0] src(input eis_pkg::t_src s);
        logic signed [eis_pkg::MUL_W-1:0] v;
        v = '0;
        unique case (s)
            eis_pkg::S_E00: v = ent(i_cfg.e_row0, 0);
            eis_pkg::S_E01: v = ent(i_cfg.e_row0, 1);
            eis_pkg::S_E02: v = ent(i_cfg.e_row0, 2);
            eis_pkg::S_E10: v = ent(i_cfg.e_row1, 0);
            eis_pkg::S_E11: v = ent(i_cfg.e_row1, 1);
            eis_pkg::S_E12: v = ent(i_cfg.e_row1, 2);
            eis_pkg::S_E20: v = ent(i_cfg.e_row2, 0);
            eis_pkg::S_E21: v = ent(i_cfg.e_row2, 1);
            eis_pkg::S_E22: v = ent(i_cfg.e_row2, 2);
            eis_pkg::S_P1X: v = eis_pkg::MUL_W'(r_item.p1_x);
            eis_pkg::S_P1Y: v = eis_pkg::MUL_W'(r_item.p1_y);
            eis_pkg::S_P1Z: v = eis_pkg::MUL_W'(r_item.p1_z);
            eis_pkg::S_P2X: v = eis_pkg::MUL_W'(r_item.p2_x);
            eis_pkg::S_P2Y: v = eis_pkg::MUL_W'(r_item.p2_y);
            eis_pkg::S_P2Z: v = eis_pkg::MUL_W'(r_item.p2_z);
            eis_pkg::S_F10: v = eis_pkg::MUL_W'(r_f10);
            eis_pkg::S_F11: v = eis_pkg::MUL_W'(r_f11);
            eis_pkg::S_F12: v = eis_pkg::MUL_W'(r_f12);
            eis_pkg::S_F20: v = eis_pkg::MUL_W'(r_f20);
            eis_pkg::S_F21: v = eis_pkg::MUL_W'(r_f21);
            eis_pkg::S_RH:  v = $signed(eis_pkg::MUL_W'(
                                   w_rmag[eis_pkg::RMAG_W-1:eis_pkg::R_SPLIT]));
            eis_pkg::S_RL:  v = $signed(eis_pkg::MUL_W'(w_rmag[eis_pkg::R_SPLIT-1:0]));
            eis_pkg::S_DL:  v = $signed(eis_pkg::MUL_W'(r_d[eis_pkg::D_SPLIT-1:0]));
            eis_pkg::S_DH:  v = $signed(eis_pkg::MUL_W'(
                                   r_d[eis_pkg::D_W-1:eis_pkg::D_SPLIT]));
            eis_pkg::S_T:   v = $signed(eis_pkg::MUL_W'(i_cfg.thresh));
            default:        v = '0;
        endcase
        return v;
    endfunction

    assign w_op         = eis_pkg::step_op(r_step);
    assign w_rabs       = r_r[eis_pkg::R_W-1] ? eis_pkg::R_W'(-r_r) : eis_pkg::R_W'(r_r);
    assign w_rmag       = w_rabs[eis_pkg::RMAG_W-1:0];
    assign o_item_ready = (r_state == ST_IDLE);

    always_comb begin
        w_va = src(w_op.a);
        w_vb = src(w_op.b);
    end

    // sampson: r^2 <= T * D, zero denominator is an outlier; algebraic: |r| <= T << 12
    always_comb begin
        if (i_cfg.use_sampson) begin
            w_inl = (r_d != '0) && (r_lhs <= eis_pkg::LHS_W'(r_rhs));
        end else begin
            w_inl = w_rmag <= {7'b0, i_cfg.thresh, 12'b0};
        end
    end

    assign w_load  = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);
    assign w_total = (w_inl && (r_count < COUNT_CAP)) ? r_count + 1'b1 : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_item_valid) begin
                        r_item  <= i_item;
                        r_step  <= '0;
                        r_f10   <= '0;
                        r_f11   <= '0;
                        r_f12   <= '0;
                        r_f20   <= '0;
                        r_f21   <= '0;
                        r_r     <= '0;
                        r_d     <= '0;
                        r_lhs   <= '0;
                        r_rhs   <= '0;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod  <= w_va * w_vb;
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    case (w_op.dst)
                        eis_pkg::D_F10: r_f10 <= r_f10 + eis_pkg::F_W'(r_prod);
                        eis_pkg::D_F11: r_f11 <= r_f11 + eis_pkg::F_W'(r_prod);
                        eis_pkg::D_F12: r_f12 <= r_f12 + eis_pkg::F_W'(r_prod);
                        eis_pkg::D_F20: r_f20 <= r_f20 + eis_pkg::F_W'(r_prod);
                        eis_pkg::D_F21: r_f21 <= r_f21 + eis_pkg::F_W'(r_prod);
                        eis_pkg::D_R:   r_r   <= r_r + eis_pkg::R_W'(r_prod);
                        eis_pkg::D_D:   r_d   <= r_d + eis_pkg::D_W'(r_prod);
                        eis_pkg::D_LHS_HI:
                            r_lhs <= r_lhs + (eis_pkg::LHS_W'(r_prod) << (2*eis_pkg::R_SPLIT));
                        // cross term counted twice
                        eis_pkg::D_LHS_MID:
                            r_lhs <= r_lhs + (eis_pkg::LHS_W'(r_prod) << (eis_pkg::R_SPLIT+1));
                        eis_pkg::D_LHS_LO:
                            r_lhs <= r_lhs + eis_pkg::LHS_W'(r_prod);
                        eis_pkg::D_RHS_LO:
                            r_rhs <= r_rhs + eis_pkg::RHS_W'(r_prod);
                        default:
                            r_rhs <= r_rhs + (eis_pkg::RHS_W'(r_prod) << eis_pkg::D_SPLIT);
                    endcase
                    if (r_step == LAST_STEP) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_step  <= r_step + 1'b1;
                        r_state <= ST_MUL;
                    end
                end
                ST_DONE: begin
                    if (w_load) begin
                        r_out_inlier <= w_inl;
                        r_out_total  <= w_total;
                        r_out_last   <= r_item.last;
                        r_count      <= r_item.last ? '0 : w_total;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b0, r_out_total, r_out_inlier};
    assign o_m_axis_tlast  = r_out_last;

    `EIS_ASSERT_NEXT(a_mul_then_acc, i_clk, i_rst_n, r_state == ST_MUL, r_state == ST_ACC)
    `EIS_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= COUNT_CAP)
    `EIS_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, w_load && r_item.last, r_count == '0)
    `EIS_ASSERT_NEXT(a_zero_denom, i_clk, i_rst_n,
                     w_load && i_cfg.use_sampson && (r_d == '0), !o_m_axis_tdata[0])

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import eis_pkg::*;

    localparam int unsigned   SAT_COUNT   = MAX_POINTS;
    localparam int unsigned   DRAIN_WAIT  = 120;
    localparam longint        CYCLE_LIMIT = 4000000;
    localparam logic [2:0]    CFG_UNUSED  = 3'd7;
    localparam logic [15:0]   Q_ONE       = 16'sd4096;
    localparam logic [15:0]   Q_ZERO      = 16'd0;

    typedef struct {
        bit          inl;
        logic [12:0] total;
        bit          last;
    } t_score;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tready;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [OUT_DATA_W-1:0]  m_tdata;
    wire                   m_tlast;

    // shadow of the block's configuration and count
    logic [ROW_W-1:0] row_sh [3];
    logic [THR_W-1:0] thr_sh;
    bit               sampson_sh;
    int unsigned      set_count;

    t_item  pending_words[$];
    t_score expected_scores[$];
    int     tx_idle_pct;
    int     rx_stall_pct;
    int     hold_req;
    int     hold_seen;
    int     hold_left;
    int     errors;
    longint cycles;

    epipolar_inlier_scorer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic bit epipolar_inlier(input t_item w);
        longint      e [3][3];
        longint      p1 [3];
        longint      p2 [3];
        longint      f1 [3];
        longint      f2 [3];
        longint      r;
        logic [63:0] m;
        logic [127:0] d;
        logic [127:0] lhs;
        p1[0] = w.p1_x; p1[1] = w.p1_y; p1[2] = w.p1_z;
        p2[0] = w.p2_x; p2[1] = w.p2_y; p2[2] = w.p2_z;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                e[i][j] = $signed(row_sh[i][16*j +: 16]);
        r = 0;
        for (int i = 0; i < 3; i++) begin
            f1[i] = e[i][0] * p1[0] + e[i][1] * p1[1] + e[i][2] * p1[2];
            f2[i] = e[0][i] * p2[0] + e[1][i] * p2[1] + e[2][i] * p2[2];
        end
        for (int i = 0; i < 3; i++) r += p2[i] * f1[i];
        m = (r < 0) ? -r : r;
        if (!sampson_sh)
            return m <= ({32'd0, thr_sh} << 12);
        lhs = {64'd0, m} * {64'd0, m};
        d = 0;
        for (int k = 0; k < 4; k++) begin
            longint f;
            logic [63:0] fm;
            f = (k == 0) ? f1[0] : (k == 1) ? f1[1] : (k == 2) ? f2[0] : f2[1];
            fm = (f < 0) ? -f : f;
            d += {64'd0, fm} * {64'd0, fm};
        end
        if (d == 0)
            return 1'b0;  // zero denominator is never an inlier
        return lhs <= d * {96'd0, thr_sh};
    endfunction

    function automatic void queue_word(input t_item w);
        pending_words = {pending_words, w};
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            set_count = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                t_item  w;
                t_score sc;
                w = pending_words.pop_front();
                w.last = s_tlast;
                sc.inl = epipolar_inlier(w);
                if (sc.inl && set_count < SAT_COUNT) set_count++;
                sc.total = set_count[12:0];
                sc.last = w.last;
                if (w.last) set_count = 0;
                expected_scores = {expected_scores, sc};
            end
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {pending_words[0].p2_z, pending_words[0].p2_y,
                                pending_words[0].p2_x, pending_words[0].p1_z,
                                pending_words[0].p1_y, pending_words[0].p1_x};
                    s_tlast <= pending_words[0].last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 400;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_scores.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    t_score sc;
                    sc = expected_scores.pop_front();
                    if (m_tdata[0] !== sc.inl) begin
                        $error("is_inlier expected %0d actual %0d", sc.inl, m_tdata[0]);
                        errors++;
                    end
                    if (m_tdata[13:1] !== sc.total) begin
                        $error("inlier_total expected %0d actual %0d", sc.total,
                               m_tdata[13:1]);
                        errors++;
                    end
                    if (m_tlast !== sc.last) begin
                        $error("last_out expected %0d actual %0d", sc.last, m_tlast);
                        errors++;
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        case (idx)
            CFG_E_ROW0: row_sh[0] = val[ROW_W-1:0];
            CFG_E_ROW1: row_sh[1] = val[ROW_W-1:0];
            CFG_E_ROW2: row_sh[2] = val[ROW_W-1:0];
            CFG_THRESH: thr_sh = val[THR_W-1:0];
            CFG_SAMPSON: sampson_sh = val[0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_words.size() == 0 && expected_scores.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic t_item make_point(input logic [15:0] ax, input logic [15:0] ay,
                                         input logic [15:0] az, input logic [15:0] bx,
                                         input logic [15:0] by, input logic [15:0] bz,
                                         input bit last);
        t_item w;
        w.p1_x = ax; w.p1_y = ay; w.p1_z = az;
        w.p2_x = bx; w.p2_y = by; w.p2_z = bz;
        w.last = last;
        return w;
    endfunction

    function automatic logic [15:0] near(input int span);
        return 16'($signed($urandom_range(2 * span)) - span);
    endfunction

    function automatic logic [15:0] any16();
        return 16'($urandom);
    endfunction

    function automatic t_item random_point();
        bit last;
        last = ($urandom_range(19) == 0);
        if ($urandom_range(9) < 8)
            return make_point(near(3000), near(3000), Q_ONE + near(30),
                              near(3000), near(3000), Q_ONE + near(30), last);
        return make_point(any16(), any16(), any16(), any16(), any16(), any16(), last);
    endfunction

    function automatic logic [47:0] random_row();
        if ($urandom_range(3) == 0)
            return {any16(), $urandom};
        return {near(600), near(600), near(600)};
    endfunction

    task automatic random_config(input int sel);
        write_reg(CFG_E_ROW0, 64'(random_row()));
        write_reg(CFG_E_ROW1, 64'(random_row()));
        write_reg(CFG_E_ROW2, 64'(random_row()));
        case (sel % 4)
            0: write_reg(CFG_THRESH, 64'hFFFF_FFFF);
            1: write_reg(CFG_THRESH, 64'd0);
            2: write_reg(CFG_THRESH, 64'($urandom_range(1 << 20)));
            default: write_reg(CFG_THRESH, 64'($urandom));
        endcase
        write_reg(CFG_SAMPSON, 64'(sel % 2));
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        row_sh[0] = '0; row_sh[1] = '0; row_sh[2] = '0;
        thr_sh = '0;
        sampson_sh = 1'b1;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_req = 0;
        errors = 0;
        cycles = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: all-zero matrix, sampson, zero denominator outlier
        queue_word(make_point(Q_ONE, Q_ZERO, Q_ONE, Q_ZERO, Q_ONE, Q_ONE, 1'b0));
        queue_word(make_point(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1));
        drain();

        // threshold equality, algebraic and sampson, with e00 = 1
        write_reg(CFG_E_ROW0, 64'd1);
        write_reg(CFG_UNUSED, 64'hFFFF_FFFF_FFFF);
        write_reg(CFG_SAMPSON, 64'd0);
        write_reg(CFG_THRESH, 64'd4096);
        queue_word(make_point(Q_ONE, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, 1'b0));
        queue_word(make_point(Q_ONE, Q_ZERO, Q_ZERO, Q_ONE + 16'd1, Q_ZERO, Q_ZERO, 1'b0));
        queue_word(make_point(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1));
        drain();
        write_reg(CFG_SAMPSON, 64'd1);
        write_reg(CFG_THRESH, 64'h80_0000);
        queue_word(make_point(Q_ONE, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, 1'b0));
        queue_word(make_point(Q_ONE, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, 1'b1));
        drain();
        write_reg(CFG_THRESH, 64'h7F_FFFF);
        queue_word(make_point(Q_ONE, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, 1'b1));
        drain();

        // field extremes with extreme matrix entries
        write_reg(CFG_E_ROW0, 64'h8000_8000_8000);
        write_reg(CFG_E_ROW1, 64'h7FFF_7FFF_7FFF);
        write_reg(CFG_E_ROW2, 64'h8000_7FFF_8000);
        write_reg(CFG_THRESH, 64'hFFFF_FFFF);
        queue_word(make_point(16'h8000, 16'h8000, 16'h8000,
                              16'h8000, 16'h8000, 16'h8000, 1'b0));
        queue_word(make_point(16'h7FFF, 16'h7FFF, 16'h7FFF,
                              16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
        queue_word(make_point(16'h8000, 16'h7FFF, 16'h8000,
                              16'h7FFF, 16'h8000, 16'h7FFF, 1'b1));
        drain();
        write_reg(CFG_SAMPSON, 64'd0);
        queue_word(make_point(16'h8000, 16'h8000, 16'h8000,
                              16'h8000, 16'h8000, 16'h8000, 1'b0));
        queue_word(make_point(16'h7FFF, 16'h8000, 16'h7FFF,
                              16'h8000, 16'h7FFF, 16'h8000, 1'b1));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct = (ph == 1 || ph == 3) ? 87 : 0;
            rx_stall_pct = (ph == 2 || ph == 3) ? 87 : 0;
            if (ph == 3) begin
                tx_idle_pct = 9;
                rx_stall_pct = 9;
            end
            for (int sub = 0; sub < 3; sub++) begin
                random_config(ph * 3 + sub + $urandom_range(1));
                if (ph == 0 && sub == 0) hold_req++;
                for (int n = 0; n < 75; n++) queue_word(random_point());
                // sender pauses until every result is in
                wait (pending_words.size() == 0 && expected_scores.size() == 0);
                for (int n = 0; n < 75; n++) queue_word(random_point());
                drain();
            end
        end

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
